@@ sv/rmwc_pkg.sv @@
// Shared types and constants of the receive match window capture block.
package rmwc_pkg;

  localparam int CAPTURE_DEPTH = 32;
  localparam int MATCH_DEPTH   = 8;
  localparam int CAP_AW        = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
  // Fill position never holds the depth itself between items, but the
  // incremented value does before the window closes.
  localparam int POS_W         = $clog2(CAPTURE_DEPTH + 1);
  localparam int CMP_W         = 16;

  localparam logic [1:0] OP_ARM   = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_ABORT = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [1:0] CFG_MATCH_LENGTH = 2'd1;
  localparam logic [1:0] CFG_MATCH_BYTES  = 2'd2;

  localparam logic [5:0]  WINDOW_SIZE_RESET  = 6'd32;
  localparam logic [3:0]  MATCH_LENGTH_RESET = 4'd0;
  localparam logic [63:0] MATCH_BYTES_RESET  = 64'd0;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic [4:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic       window_open;
    logic [4:0] position;
    logic [7:0] data;
    logic       mismatch;
    logic       window_done;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [CAP_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [CAP_AW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic      rd;
    logic      rd_ok;
    out_item_t item;
  } stage_t;

endpackage

@@ sv/rmwc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module rmwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/rmwc_ctrl.sv @@
// Window control: configuration registers, fill position and window state.
module rmwc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                accept,
  input  rmwc_pkg::in_item_t  req,
  output rmwc_pkg::ram_req_t  ram_req,
  output rmwc_pkg::stage_t    stage
);

  logic [5:0]  window_size;
  logic [3:0]  match_length;
  logic [63:0] match_bytes;

  logic [rmwc_pkg::POS_W-1:0] fill_position, fill_position_next;
  logic                       window_active, window_active_next;

  logic [rmwc_pkg::CMP_W-1:0] size_ext, mlen_ext, pos_ext, pos_inc, ridx_ext;
  logic [7:0]                 want;
  logic                       in_prefix;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= rmwc_pkg::WINDOW_SIZE_RESET;
      match_length <= rmwc_pkg::MATCH_LENGTH_RESET;
      match_bytes  <= rmwc_pkg::MATCH_BYTES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rmwc_pkg::CFG_WINDOW_SIZE:  window_size  <= cfg_data[5:0];
        rmwc_pkg::CFG_MATCH_LENGTH: match_length <= cfg_data[3:0];
        rmwc_pkg::CFG_MATCH_BYTES:  match_bytes  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    size_ext = rmwc_pkg::CMP_W'(window_size);
    if (size_ext > rmwc_pkg::CMP_W'(rmwc_pkg::CAPTURE_DEPTH)) begin
      size_ext = rmwc_pkg::CMP_W'(rmwc_pkg::CAPTURE_DEPTH);
    end
    mlen_ext = rmwc_pkg::CMP_W'(match_length);
    if (mlen_ext > rmwc_pkg::CMP_W'(rmwc_pkg::MATCH_DEPTH)) begin
      mlen_ext = rmwc_pkg::CMP_W'(rmwc_pkg::MATCH_DEPTH);
    end
    pos_ext   = rmwc_pkg::CMP_W'(fill_position);
    pos_inc   = pos_ext + rmwc_pkg::CMP_W'(1);
    ridx_ext  = rmwc_pkg::CMP_W'(req.read_index);
    want      = match_bytes[{pos_ext[2:0], 3'b000} +: 8];
    in_prefix = (pos_ext < mlen_ext) && (pos_ext < rmwc_pkg::CMP_W'(8));

    fill_position_next = fill_position;
    window_active_next = window_active;
    ram_req            = '0;
    ram_req.waddr      = fill_position[rmwc_pkg::CAP_AW-1:0];
    ram_req.wdata      = req.rx_byte;
    ram_req.raddr      = ridx_ext[rmwc_pkg::CAP_AW-1:0];
    stage              = '0;

    case (req.op)
      rmwc_pkg::OP_ARM: begin
        if (!window_active) begin
          window_active_next = 1'b1;
          fill_position_next = '0;
        end
      end
      rmwc_pkg::OP_BYTE: begin
        if (window_active) begin
          ram_req.we          = 1'b1;
          stage.item.position = fill_position[4:0];
          stage.item.data     = req.rx_byte;
          if (in_prefix && (req.rx_byte != want)) begin
            // A broken prefix restarts the match; the byte stays stored.
            stage.item.mismatch = 1'b1;
            pos_inc             = '0;
          end
          if (size_ext <= pos_inc) begin
            window_active_next     = 1'b0;
            fill_position_next     = '0;
            stage.item.window_done = 1'b1;
          end else begin
            fill_position_next = pos_inc[rmwc_pkg::POS_W-1:0];
          end
        end
      end
      rmwc_pkg::OP_ABORT: begin
        window_active_next = 1'b0;
        fill_position_next = '0;
      end
      rmwc_pkg::OP_READ: begin
        ram_req.re          = 1'b1;
        stage.rd            = 1'b1;
        stage.rd_ok         = ridx_ext < rmwc_pkg::CMP_W'(rmwc_pkg::CAPTURE_DEPTH);
        stage.item.position = req.read_index;
      end
      default: ;
    endcase
    stage.item.window_open = window_active_next;

    if (!accept) begin
      ram_req.we = 1'b0;
      ram_req.re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_position <= '0;
      window_active <= 1'b0;
    end else if (accept) begin
      fill_position <= fill_position_next;
      window_active <= window_active_next;
    end
  end

endmodule

@@ sv/rx_match_window_capture.sv @@
// Top level of the receive match window capture block.
//
// Items arrive on the req channel (req_valid, req_stall, req) and each one
// gives exactly one result item on the rsp channel (rsp_valid, rsp_stall,
// rsp). Arm, abort and byte items update the window state at acceptance;
// byte items write the capture RAM in that same cycle. Read items read the
// capture RAM, whose output is registered. Every result passes through the
// RAM stage and the output register, and one item can be accepted in every
// cycle while req_stall is low. Configuration must be written through
// cfg_we, cfg_index and cfg_data only while no item is in flight; the block
// does not enforce this. Writes take effect on the next byte.
// A synchronous reset closes the window, clears the fill position, restores
// the register defaults and empties the pipeline; the RAM keeps its contents
// and holds nothing valid until written. When the receiver stalls, the RAM
// stage and the output register fill up, and req_stall rises only while both
// are full and rsp_stall is high.
module rx_match_window_capture (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                req_valid,
  output logic                req_stall,
  input  rmwc_pkg::in_item_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rmwc_pkg::out_item_t rsp
);

  rmwc_pkg::ram_req_t  ram_req;
  rmwc_pkg::stage_t    stage_new, s1;
  rmwc_pkg::out_item_t s1_out;
  logic                s1_valid;
  logic                s1_move;
  logic                accept;
  logic [7:0]          rd_data;

  assign s1_move   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !s1_move;
  assign accept    = req_valid && !req_stall;

  rmwc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .req       (req),
    .ram_req   (ram_req),
    .stage     (stage_new)
  );

  rmwc_ram #(
    .WIDTH (8),
    .DEPTH (rmwc_pkg::CAPTURE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  // The RAM output only changes on a new read, which cannot be accepted
  // while this stage holds, so it stays valid for a stalled read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= stage_new;
    end
  end

  always_comb begin
    s1_out = s1.item;
    if (s1.rd) begin
      s1_out.data = s1.rd_ok ? rd_data : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp <= s1_out;
    end
  end

endmodule
